// File: design/imutf_pkg.sv
// ----------------------------------------------------------------------------
// imutf_pkg
// Shared types, constants and the CORDIC angle table of the tilt filter.
// ----------------------------------------------------------------------------
package imutf_pkg;

  // field widths
  localparam int RAW_W  = 16;
  localparam int TILT_W = 17;
  localparam int REG_W  = 16;

  // default parameter values
  localparam int DEF_ANGLE_FRAC_BITS = 8;
  localparam int DEF_CORDIC_STEPS    = 16;

  // sequencer counts
  localparam int TABLE_LEN  = 24;
  localparam int IDX_W      = 5;
  localparam int SQRT_STEPS = 31;

  // configuration reset values
  localparam logic [REG_W-1:0] BLEND_WEIGHT_RST = 16'd64225;
  localparam logic [REG_W-1:0] GYRO_GAIN_RST    = 16'd10246;

  // register indexes
  localparam logic REG_BLEND_WEIGHT = 1'b0;
  localparam logic REG_GYRO_GAIN    = 1'b1;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQ1,
    OP_SQ2,
    OP_SQ3,
    OP_SQRT,
    OP_CSET,
    OP_CORD,
    OP_CRND,
    OP_B0,
    OP_B1,
    OP_B2,
    OP_B3,
    OP_B4,
    OP_B5,
    OP_OUT
  } dp_op_t;

  typedef enum logic [1:0] {
    AX_X,
    AX_Y,
    AX_Z
  } axis_t;

  typedef struct packed {
    dp_op_t           op;
    axis_t            axis;
    logic [IDX_W-1:0] step;
  } dp_cmd_t;

  typedef struct packed {
    logic out_valid;
  } dp_status_t;

  typedef struct packed {
    logic [REG_W-1:0] blend_weight;
    logic [REG_W-1:0] gyro_gain;
  } cfg_regs_t;

  // atan(2^-i) in degrees, Q24
  function automatic logic signed [33:0] atan_q24(input logic [IDX_W-1:0] idx);
    logic signed [33:0] v;
    case (idx)
      5'd0:  v = 34'sd754974720;
      5'd1:  v = 34'sd445687602;
      5'd2:  v = 34'sd235489088;
      5'd3:  v = 34'sd119537938;
      5'd4:  v = 34'sd60000934;
      5'd5:  v = 34'sd30029717;
      5'd6:  v = 34'sd15018523;
      5'd7:  v = 34'sd7509720;
      5'd8:  v = 34'sd3754917;
      5'd9:  v = 34'sd1877466;
      5'd10: v = 34'sd938734;
      5'd11: v = 34'sd469367;
      5'd12: v = 34'sd234684;
      5'd13: v = 34'sd117342;
      5'd14: v = 34'sd58671;
      5'd15: v = 34'sd29335;
      5'd16: v = 34'sd14668;
      5'd17: v = 34'sd7334;
      5'd18: v = 34'sd3667;
      5'd19: v = 34'sd1833;
      5'd20: v = 34'sd917;
      5'd21: v = 34'sd458;
      5'd22: v = 34'sd229;
      5'd23: v = 34'sd115;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: design/imutf_in_if.sv
// ----------------------------------------------------------------------------
// imutf_in_if
// Sample channel: one six-axis sample per transfer.
// ----------------------------------------------------------------------------
interface imutf_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [imutf_pkg::RAW_W-1:0]  accel_x;
  logic signed [imutf_pkg::RAW_W-1:0]  accel_y;
  logic signed [imutf_pkg::RAW_W-1:0]  accel_z;
  logic signed [imutf_pkg::RAW_W-1:0]  gyro_x;
  logic signed [imutf_pkg::RAW_W-1:0]  gyro_y;
  logic signed [imutf_pkg::RAW_W-1:0]  gyro_z;

  modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                  input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                output ready);
endinterface

// File: design/imutf_out_if.sv
// ----------------------------------------------------------------------------
// imutf_out_if
// Result channel: three tilt estimates per transfer.
// ----------------------------------------------------------------------------
interface imutf_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [imutf_pkg::TILT_W-1:0] tilt_x;
  logic signed [imutf_pkg::TILT_W-1:0] tilt_y;
  logic signed [imutf_pkg::TILT_W-1:0] tilt_z;

  modport source (output valid, tilt_x, tilt_y, tilt_z, input ready);
  modport sink (input valid, tilt_x, tilt_y, tilt_z, output ready);
endinterface

// File: design/imutf_cfg.sv
// ----------------------------------------------------------------------------
// imutf_cfg
// APB register file holding blend weight and gyro gain.
// ----------------------------------------------------------------------------
module imutf_cfg (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  output imutf_pkg::cfg_regs_t    regs
);

  logic [imutf_pkg::REG_W-1:0] blend_weight_r;
  logic [imutf_pkg::REG_W-1:0] gyro_gain_r;
  logic                        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blend_weight_r <= imutf_pkg::BLEND_WEIGHT_RST;
      gyro_gain_r    <= imutf_pkg::GYRO_GAIN_RST;
    end else if (wr_en) begin
      if (paddr[2] == imutf_pkg::REG_BLEND_WEIGHT) begin
        blend_weight_r <= pwdata[imutf_pkg::REG_W-1:0];
      end else begin
        gyro_gain_r <= pwdata[imutf_pkg::REG_W-1:0];
      end
    end
  end

  // read mux
  always_comb begin
    if (paddr[2] == imutf_pkg::REG_GYRO_GAIN) begin
      prdata = {16'd0, gyro_gain_r};
    end else begin
      prdata = {16'd0, blend_weight_r};
    end
  end

  assign regs.blend_weight = blend_weight_r;
  assign regs.gyro_gain    = gyro_gain_r;

endmodule

// File: design/imutf_ctrl.sv
// ----------------------------------------------------------------------------
// imutf_ctrl
// Sequencer: per axis square root, CORDIC and blend, then result hand-off.
// ----------------------------------------------------------------------------
module imutf_ctrl #(
  parameter int CORDIC_STEPS = imutf_pkg::DEF_CORDIC_STEPS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   out_ready,
  input  imutf_pkg::dp_status_t  status,
  output imutf_pkg::dp_cmd_t     cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_SQ1, S_SQ2, S_SQ3, S_SQRT, S_CSET, S_CORD, S_CRND,
    S_B0, S_B1, S_B2, S_B3, S_B4, S_B5, S_DONE
  } state_t;

  localparam logic [imutf_pkg::IDX_W-1:0] SQRT_LAST =
    imutf_pkg::IDX_W'(imutf_pkg::SQRT_STEPS - 1);
  localparam logic [imutf_pkg::IDX_W-1:0] CORD_LAST =
    imutf_pkg::IDX_W'(CORDIC_STEPS - 1);

  state_t                        state_r, state_nxt;
  imutf_pkg::axis_t              axis_r, axis_nxt;
  logic [imutf_pkg::IDX_W-1:0]   cnt_r, cnt_nxt;
  logic                          out_free;

  assign out_free = !status.out_valid || out_ready;
  assign in_ready = (state_r == S_IDLE);

  // next state and command
  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    cnt_nxt   = cnt_r;
    cmd.op    = imutf_pkg::OP_NONE;
    cmd.axis  = axis_r;
    cmd.step  = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = imutf_pkg::OP_LOAD;
          axis_nxt  = imutf_pkg::AX_X;
          state_nxt = S_SQ1;
        end
      end
      S_SQ1: begin
        cmd.op    = imutf_pkg::OP_SQ1;
        state_nxt = S_SQ2;
      end
      S_SQ2: begin
        cmd.op    = imutf_pkg::OP_SQ2;
        state_nxt = S_SQ3;
      end
      S_SQ3: begin
        cmd.op    = imutf_pkg::OP_SQ3;
        cnt_nxt   = '0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.op  = imutf_pkg::OP_SQRT;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == SQRT_LAST) begin
          state_nxt = S_CSET;
        end
      end
      S_CSET: begin
        cmd.op    = imutf_pkg::OP_CSET;
        cnt_nxt   = '0;
        state_nxt = S_CORD;
      end
      S_CORD: begin
        cmd.op  = imutf_pkg::OP_CORD;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CORD_LAST) begin
          state_nxt = S_CRND;
        end
      end
      S_CRND: begin
        cmd.op    = imutf_pkg::OP_CRND;
        state_nxt = S_B0;
      end
      S_B0: begin
        cmd.op    = imutf_pkg::OP_B0;
        state_nxt = S_B1;
      end
      S_B1: begin
        cmd.op    = imutf_pkg::OP_B1;
        state_nxt = S_B2;
      end
      S_B2: begin
        cmd.op    = imutf_pkg::OP_B2;
        state_nxt = S_B3;
      end
      S_B3: begin
        cmd.op    = imutf_pkg::OP_B3;
        state_nxt = S_B4;
      end
      S_B4: begin
        cmd.op    = imutf_pkg::OP_B4;
        state_nxt = S_B5;
      end
      S_B5: begin
        cmd.op = imutf_pkg::OP_B5;
        case (axis_r)
          imutf_pkg::AX_X: begin
            axis_nxt  = imutf_pkg::AX_Y;
            state_nxt = S_SQ1;
          end
          imutf_pkg::AX_Y: begin
            axis_nxt  = imutf_pkg::AX_Z;
            state_nxt = S_SQ1;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_DONE: begin
        if (out_free) begin
          cmd.op    = imutf_pkg::OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      axis_r  <= imutf_pkg::AX_X;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// File: design/imutf_dp.sv
// ----------------------------------------------------------------------------
// imutf_dp
// Datapath: shared multiplier, bit-serial square root, CORDIC, blend, output.
// ----------------------------------------------------------------------------
module imutf_dp #(
  parameter int ANGLE_FRAC_BITS = imutf_pkg::DEF_ANGLE_FRAC_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  imutf_pkg::dp_cmd_t                    cmd,
  input  imutf_pkg::cfg_regs_t                  cfg,
  input  logic signed [imutf_pkg::RAW_W-1:0]    accel_x,
  input  logic signed [imutf_pkg::RAW_W-1:0]    accel_y,
  input  logic signed [imutf_pkg::RAW_W-1:0]    accel_z,
  input  logic signed [imutf_pkg::RAW_W-1:0]    gyro_x,
  input  logic signed [imutf_pkg::RAW_W-1:0]    gyro_y,
  input  logic                                  out_ready,
  output imutf_pkg::dp_status_t                 status,
  output logic                                  out_valid,
  output logic signed [imutf_pkg::TILT_W-1:0]   tilt_x,
  output logic signed [imutf_pkg::TILT_W-1:0]   tilt_y,
  output logic signed [imutf_pkg::TILT_W-1:0]   tilt_z
);

  localparam int F     = ANGLE_FRAC_BITS;
  localparam int EW    = 9 + F;        // estimate width
  localparam int SW    = 50 + F;       // blend sum width
  localparam int RW    = SW - 36;      // rounded blend width
  localparam int ZR    = 10 + F;       // rounded cordic angle width
  localparam int CW    = 35;           // cordic x and y width
  localparam int BW    = 34;           // multiplier signed operand width
  localparam int PW    = 52;           // product width
  localparam int TW    = imutf_pkg::TILT_W;
  localparam logic signed [EW-1:0] DEG90  = EW'(90 * (2 ** F));
  localparam logic signed [RW-1:0] SAT    = RW'(180 * (2 ** F));
  localparam logic signed [33:0]   ZHALF  = 34'(2 ** (23 - F));
  localparam logic signed [SW-1:0] BHALF  = SW'(64'sd1 <<< 35);

  function automatic logic [16:0] mag16(input logic signed [15:0] v);
    logic signed [16:0] e;
    e = 17'(v);
    return e[16] ? 17'(-e) : e;
  endfunction

  // captured sample
  logic signed [15:0]       ax_r, ay_r, az_r, gx_r, gy_r;
  // multiplier
  logic [16:0]              mul_a;
  logic signed [BW-1:0]     mul_b;
  logic signed [PW-1:0]     prod_r;
  // square root
  logic [31:0]              sq_r;
  logic [31:0]              sq_sum;
  logic [61:0]              rad_r;
  logic [32:0]              rem_r;
  logic [30:0]              res_r;
  logic [34:0]              rem_t;
  logic [34:0]              trial;
  // cordic
  logic signed [32:0]       num_s, den_s;
  logic signed [CW-1:0]     cx_r, cy_r, xs, ys;
  logic signed [33:0]       cz_r, cz_h;
  logic signed [ZR-1:0]     zr;
  logic                     neg_r, numneg_r, ynz_r, xz_r;
  logic signed [EW-1:0]     acc_r;
  // blend
  logic signed [SW-1:0]     sum_r, prod_ext, sum_h;
  logic signed [RW-1:0]     rnd;
  logic signed [EW-1:0]     est_r [3];
  logic signed [EW-1:0]     est_sel, est_new;
  logic signed [15:0]       gyro_sel, p_op, q_op;
  logic [1:0]               ai;
  // output
  logic                     out_valid_r;
  logic signed [TW-1:0]     tx_r, ty_r, tz_r;
  logic signed [EW+TW-1:0]  ex0, ex1, ex2;

  assign ai = cmd.axis;

  // per-axis operand selection
  always_comb begin
    case (cmd.axis)
      imutf_pkg::AX_X: begin
        p_op = ax_r; q_op = az_r; gyro_sel = gx_r;
        num_s = 33'(ay_r) <<< 15; den_s = 33'({2'b00, res_r});
      end
      imutf_pkg::AX_Y: begin
        p_op = ay_r; q_op = az_r; gyro_sel = gy_r;
        num_s = 33'(ax_r) <<< 15; den_s = 33'({2'b00, res_r});
      end
      default: begin
        p_op = ax_r; q_op = ay_r; gyro_sel = '0;
        num_s = 33'({2'b00, res_r}); den_s = 33'(az_r) <<< 15;
      end
    endcase
  end

  assign est_sel = est_r[ai];

  // shared multiplier operands
  always_comb begin
    case (cmd.op)
      imutf_pkg::OP_SQ1: begin
        mul_a = mag16(p_op); mul_b = BW'(mag16(p_op));
      end
      imutf_pkg::OP_SQ2: begin
        mul_a = mag16(q_op); mul_b = BW'(mag16(q_op));
      end
      imutf_pkg::OP_B0: begin
        mul_a = 17'(cfg.gyro_gain); mul_b = BW'(gyro_sel);
      end
      imutf_pkg::OP_B1: begin
        mul_a = 17'(cfg.blend_weight); mul_b = prod_r[BW-1:0];
      end
      imutf_pkg::OP_B2: begin
        mul_a = 17'(cfg.blend_weight); mul_b = BW'(est_sel);
      end
      imutf_pkg::OP_B3: begin
        mul_a = 17'(18'd65536 - 18'(cfg.blend_weight)); mul_b = BW'(acc_r);
      end
      default: begin
        mul_a = '0; mul_b = '0;
      end
    endcase
  end

  // square root step and sum of squares
  assign sq_sum = sq_r + prod_r[31:0];
  assign rem_t  = {rem_r, rad_r[61:60]};
  assign trial  = {2'b00, res_r, 2'b01};

  // cordic shifts and rounding
  assign xs   = cx_r >>> cmd.step;
  assign ys   = cy_r >>> cmd.step;
  assign cz_h = cz_r + ZHALF;
  assign zr   = ZR'(cz_h >>> (24 - F));

  // blend rounding and saturation
  assign prod_ext = SW'(prod_r);
  assign sum_h    = sum_r + BHALF;
  assign rnd      = RW'(sum_h >>> 36);
  always_comb begin
    if (rnd > SAT) begin
      est_new = EW'(SAT);
    end else if (rnd < -SAT) begin
      est_new = EW'(-SAT);
    end else begin
      est_new = EW'(rnd);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      imutf_pkg::OP_LOAD: begin
        ax_r <= accel_x; ay_r <= accel_y; az_r <= accel_z;
        gx_r <= gyro_x;  gy_r <= gyro_y;
      end
      imutf_pkg::OP_SQ2: begin
        sq_r <= prod_r[31:0];
      end
      imutf_pkg::OP_SQ3: begin
        rad_r <= {sq_sum, 30'd0};
        rem_r <= '0;
        res_r <= '0;
      end
      imutf_pkg::OP_SQRT: begin
        rad_r <= {rad_r[59:0], 2'b00};
        if (rem_t >= trial) begin
          rem_r <= 33'(rem_t - trial);
          res_r <= {res_r[29:0], 1'b1};
        end else begin
          rem_r <= rem_t[32:0];
          res_r <= {res_r[29:0], 1'b0};
        end
      end
      imutf_pkg::OP_CSET: begin
        cy_r     <= num_s[32] ? CW'(-num_s) : CW'(num_s);
        cx_r     <= den_s[32] ? CW'(-den_s) : CW'(den_s);
        cz_r     <= '0;
        neg_r    <= num_s[32] ^ den_s[32];
        numneg_r <= num_s[32];
        ynz_r    <= (num_s != '0);
        xz_r     <= (den_s == '0);
      end
      imutf_pkg::OP_CORD: begin
        if (cy_r > 0) begin
          cx_r <= cx_r + ys;
          cy_r <= cy_r - xs;
          cz_r <= cz_r + imutf_pkg::atan_q24(cmd.step);
        end else begin
          cx_r <= cx_r - ys;
          cy_r <= cy_r + xs;
          cz_r <= cz_r - imutf_pkg::atan_q24(cmd.step);
        end
      end
      imutf_pkg::OP_CRND: begin
        if (!ynz_r) begin
          acc_r <= '0;
        end else if (xz_r) begin
          acc_r <= numneg_r ? -DEG90 : DEG90;
        end else begin
          acc_r <= neg_r ? EW'(-zr) : EW'(zr);
        end
      end
      imutf_pkg::OP_B2: begin
        sum_r <= prod_ext;
      end
      imutf_pkg::OP_B3, imutf_pkg::OP_B4: begin
        sum_r <= sum_r + (prod_ext <<< 20);
      end
      default: begin
      end
    endcase
    prod_r <= $signed({1'b0, mul_a}) * mul_b;
  end

  // estimate state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      est_r[0] <= '0;
      est_r[1] <= '0;
      est_r[2] <= '0;
    end else if (cmd.op == imutf_pkg::OP_B5) begin
      est_r[ai] <= est_new;
    end
  end

  // result register
  assign ex0 = (EW+TW)'(est_r[0]);
  assign ex1 = (EW+TW)'(est_r[1]);
  assign ex2 = (EW+TW)'(est_r[2]);

  always_ff @(posedge clk) begin
    if (cmd.op == imutf_pkg::OP_OUT) begin
      tx_r <= ex0[TW-1:0];
      ty_r <= ex1[TW-1:0];
      tz_r <= ex2[TW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == imutf_pkg::OP_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign status.out_valid = out_valid_r;
  assign tilt_x           = tx_r;
  assign tilt_y           = ty_r;
  assign tilt_z           = tz_r;

endmodule

// File: design/imu_tilt_complementary_filter_unit.sv
// ----------------------------------------------------------------------------
// imu_tilt_complementary_filter_unit
// Processing: one sample at a time; a new sample is accepted only once the
//   previous result has been handed to the output register.
//   The hand-off waits while an earlier result is still held and not taken;
//   each axis runs a bit-serial square root and the shared CORDIC and
//   multiplier in turn.
// Reset: synchronous active-low; clears the estimates and loads register defaults.
// ----------------------------------------------------------------------------
module imu_tilt_complementary_filter_unit #(
  parameter int ANGLE_FRAC_BITS = imutf_pkg::DEF_ANGLE_FRAC_BITS,
  parameter int CORDIC_STEPS    = imutf_pkg::DEF_CORDIC_STEPS
) (
  input  logic         clk,
  input  logic         rst_n,
  imutf_in_if.sink     in_ch,
  imutf_out_if.source  out_ch,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  imutf_pkg::dp_cmd_t    cmd;
  imutf_pkg::dp_status_t status;
  imutf_pkg::cfg_regs_t  regs;

  // configuration registers
  imutf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .regs    (regs)
  );

  // sequencer
  imutf_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath
  imutf_dp #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cfg       (regs),
    .accel_x   (in_ch.accel_x),
    .accel_y   (in_ch.accel_y),
    .accel_z   (in_ch.accel_z),
    .gyro_x    (in_ch.gyro_x),
    .gyro_y    (in_ch.gyro_y),
    .out_ready (out_ch.ready),
    .status    (status),
    .out_valid (out_ch.valid),
    .tilt_x    (out_ch.tilt_x),
    .tilt_y    (out_ch.tilt_y),
    .tilt_z    (out_ch.tilt_z)
  );

endmodule
